FILE: sv/sem_pkg.sv
// shared types and constants for the sobel edge magnitude core
`timescale 1ns / 1ps
package sem_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SENSITIVITY  = 2'd2;

  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [15:0] SENS_RST         = 16'd256;

  // luma weights in thousandths
  localparam logic [9:0] W_RED   = 10'd299;
  localparam logic [9:0] W_GREEN = 10'd587;
  localparam logic [9:0] W_BLUE  = 10'd114;

  // ceil(2^28 / 1000), exact floor for sums below 2^18
  localparam logic [18:0] RECIP_1000 = 19'd268436;
  localparam int          RECIP_SHIFT = 28;

  // number of root bits out of the 21-bit sum of squares
  localparam int SQRT_BITS = 11;

  typedef struct packed {
    logic load;
    logic gray_sum;
    logic gray_div;
    logic win_upd;
    logic sob;
    logic sqr;
    logic sqrt_step;
    logic scale;
    logic last;
    logic rsel;
    logic csel;
  } sem_cmd_t;

  typedef struct packed {
    logic [1:0] rmask;
    logic [1:0] cmask;
    logic       sqrt_last;
    logic       out_fire;
  } sem_status_t;

endpackage

FILE: sv/sobel_edge_magnitude_core.sv
// top level of the sobel edge magnitude core
`timescale 1ns / 1ps
// usage:
//   pixels enter on the s_axis word channel in raster order, one rgb word each;
//   results leave on the m_axis word channel, up to four per pixel near the
//   last row or column, each carrying its edge value, row and column
//   tlast marks the final result of a pixel, tuser marks the frame's last pixel
//   configuration words (width, height, gain) go in on the cfg channel while
//   the core is idle; cfg_ready_o is always high
// sequence:
//   one pixel is in work at a time; a pixel that makes no result frees the
//   input once its window is updated; each result passes the gradient, square,
//   11-step bitwise square root and scaling states, and a further result of the
//   same pixel starts only once the one before has been taken
// reset:
//   clears the raster position, the configuration to 640 x 480 with unit gain,
//   and the output valid; line buffers and window fill as pixels arrive
// stall:
//   a result waits in the output register until taken; no further work starts
module sobel_edge_magnitude_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red, green, blue
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // edge_value, pixel_row, pixel_col, zero pad
  output logic        m_axis_tlast,   // last_of_run
  output logic        m_axis_tuser,   // frame_done
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);

  sem_pkg::sem_cmd_t    cmd;
  sem_pkg::sem_status_t status;

  // registers accept a write in any cycle
  assign cfg_ready_o = 1'b1;

  // sequencing of one pixel and its results
  sem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // line buffers, window and arithmetic
  sem_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_done_o  (m_axis_tuser)
  );

endmodule

FILE: sv/sem_ctrl.sv
// sequencing state machine for the sobel edge magnitude core
`timescale 1ns / 1ps
module sem_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sem_pkg::sem_status_t status_i,
  output sem_pkg::sem_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GRAY  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_WIN   = 4'd3;
  localparam logic [3:0] S_SOB   = 4'd4;
  localparam logic [3:0] S_SQR   = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_SCALE = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       rsel_q, rsel_d;
  logic       csel_q, csel_d;
  logic       has_next;

  // another (row, col) pair follows in raster order
  assign has_next = (!csel_q && status_i.cmask[1]) || (!rsel_q && status_i.rmask[1]);

  always_comb begin
    state_d    = state_q;
    rsel_d     = rsel_q;
    csel_d     = csel_q;
    cmd_o      = '0;
    cmd_o.rsel = rsel_q;
    cmd_o.csel = csel_q;
    cmd_o.last = !has_next;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_GRAY;
        end
      end
      S_GRAY: begin
        cmd_o.gray_sum = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.gray_div = 1'b1;
        state_d        = S_WIN;
      end
      S_WIN: begin
        cmd_o.win_upd = 1'b1;
        if (status_i.rmask == 2'b00 || status_i.cmask == 2'b00) begin
          state_d = S_IDLE;
        end else begin
          rsel_d  = !status_i.rmask[0];
          csel_d  = !status_i.cmask[0];
          state_d = S_SOB;
        end
      end
      S_SOB: begin
        cmd_o.sob = 1'b1;
        state_d   = S_SQR;
      end
      S_SQR: begin
        cmd_o.sqr = 1'b1;
        state_d   = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (status_i.sqrt_last) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_fire) begin
          if (has_next) begin
            if (!csel_q && status_i.cmask[1]) begin
              csel_d = 1'b1;
            end else begin
              rsel_d = 1'b1;
              csel_d = !status_i.cmask[0];
            end
            state_d = S_SOB;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rsel_q  <= 1'b0;
      csel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rsel_q  <= rsel_d;
      csel_q  <= csel_d;
    end
  end

endmodule

FILE: sv/sem_datapath.sv
// line buffer, window, gradient, square root and scaling datapath
`timescale 1ns / 1ps
module sem_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_addr_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic [23:0]          pix_i,
  input  sem_pkg::sem_cmd_t    cmd_i,
  output sem_pkg::sem_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          out_data_o,
  output logic                 out_last_o,
  output logic                 out_done_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WC  = $clog2(MAX_WIDTH + 1);
  localparam int HC  = $clog2(MAX_HEIGHT + 1);
  localparam int WX  = (WC > 11) ? WC : 11;
  localparam int HX  = (HC > 13) ? HC : 13;

  // configuration
  logic [10:0] fw_q;
  logic [12:0] fh_q;
  logic [15:0] sens_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= sem_pkg::FRAME_WIDTH_RST;
      fh_q   <= sem_pkg::FRAME_HEIGHT_RST;
      sens_q <= sem_pkg::SENS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        sem_pkg::CFG_FRAME_WIDTH:  fw_q   <= cfg_wdata_i[10:0];
        sem_pkg::CFG_FRAME_HEIGHT: fh_q   <= cfg_wdata_i[12:0];
        sem_pkg::CFG_SENSITIVITY:  sens_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective frame size, zero acts as one, clipped at the maximum
  logic [WX-1:0] w_eff, w_m1;
  logic [HX-1:0] h_eff, h_m1;

  always_comb begin
    if (fw_q == '0) begin
      w_eff = WX'(1);
    end else if (WX'(fw_q) > WX'(MAX_WIDTH)) begin
      w_eff = WX'(MAX_WIDTH);
    end else begin
      w_eff = WX'(fw_q);
    end
    if (fh_q == '0) begin
      h_eff = HX'(1);
    end else if (HX'(fh_q) > HX'(MAX_HEIGHT)) begin
      h_eff = HX'(MAX_HEIGHT);
    end else begin
      h_eff = HX'(fh_q);
    end
    w_m1 = w_eff - WX'(1);
    h_m1 = h_eff - HX'(1);
  end

  // raster position: next input and current item
  logic [CW-1:0] pcol_q, ccol_q, c_n;
  logic [RW-1:0] prow_q, crow_q, r_n, r_tmp;
  logic [WX-1:0] c_inc;
  logic [HX-1:0] r_inc;

  always_comb begin
    r_tmp = prow_q;
    c_n   = pcol_q;
    if (WX'(pcol_q) >= w_eff) begin
      c_n   = '0;
      r_tmp = prow_q + RW'(1);
    end
    r_n   = (HX'(r_tmp) >= h_eff) ? '0 : r_tmp;
    c_inc = WX'(c_n) + WX'(1);
    r_inc = HX'(r_n) + HX'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcol_q <= '0;
      prow_q <= '0;
    end else if (cmd_i.load) begin
      if (c_inc >= w_eff) begin
        pcol_q <= '0;
        prow_q <= (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
      end else begin
        pcol_q <= c_inc[CW-1:0];
        prow_q <= r_n;
      end
    end
  end

  // pixel, luma and line buffer
  logic [7:0]  red_q, grn_q, blu_q;
  logic [17:0] gsum_q;
  logic [7:0]  gray_q;
  logic [36:0] gprod;
  logic [15:0] lb_mem [MAX_WIDTH];
  logic [15:0] lb_rd_q;
  logic [7:0]  win_q [9];

  assign gprod = 37'(gsum_q) * 37'(sem_pkg::RECIP_1000);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      red_q  <= pix_i[7:0];
      grn_q  <= pix_i[15:8];
      blu_q  <= pix_i[23:16];
      ccol_q <= c_n;
      crow_q <= r_n;
    end
    if (cmd_i.gray_sum) begin
      gsum_q  <= 18'(red_q) * 18'(sem_pkg::W_RED) + 18'(grn_q) * 18'(sem_pkg::W_GREEN)
               + 18'(blu_q) * 18'(sem_pkg::W_BLUE);
      lb_rd_q <= lb_mem[ccol_q];
    end
    if (cmd_i.gray_div) begin
      gray_q <= gprod[sem_pkg::RECIP_SHIFT+7:sem_pkg::RECIP_SHIFT];
    end
    if (cmd_i.win_upd) begin
      // upper byte holds row r-2, lower byte row r-1
      lb_mem[ccol_q] <= {lb_rd_q[7:0], gray_q};
      for (int i = 0; i < 3; i++) begin
        win_q[i*3]   <= win_q[i*3+1];
        win_q[i*3+1] <= win_q[i*3+2];
      end
      win_q[2] <= lb_rd_q[15:8];
      win_q[5] <= lb_rd_q[7:0];
      win_q[8] <= gray_q;
    end
  end

  // output pixel position and its border flags
  logic [RW-1:0] out_r;
  logic [CW-1:0] out_c;
  logic          at_top, at_bot, at_lft, at_rgt;
  logic [1:0]    wr [3];
  logic [1:0]    wc [3];
  logic [7:0]    pm [3][3];
  logic [3:0]    widx;
  logic signed [11:0] gx, gy;

  always_comb begin
    out_r  = crow_q - RW'(1) + RW'(cmd_i.rsel);
    out_c  = ccol_q - CW'(1) + CW'(cmd_i.csel);
    at_top = (out_r == '0);
    at_lft = (out_c == '0);
    at_bot = (HX'(out_r) == h_m1);
    at_rgt = (WX'(out_c) == w_m1);
    // window row and column of each kernel tap, edges replicated
    wr[1] = cmd_i.rsel ? 2'd2 : 2'd1;
    wr[0] = at_top ? wr[1] : wr[1] - 2'd1;
    wr[2] = (at_bot || wr[1] == 2'd2) ? wr[1] : wr[1] + 2'd1;
    wc[1] = cmd_i.csel ? 2'd2 : 2'd1;
    wc[0] = at_lft ? wc[1] : wc[1] - 2'd1;
    wc[2] = (at_rgt || wc[1] == 2'd2) ? wc[1] : wc[1] + 2'd1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        widx     = 4'({2'b00, wr[i]} * 4'd3) + {2'b00, wc[j]};
        pm[i][j] = win_q[widx];
      end
    end
    gx = (12'(pm[0][2]) - 12'(pm[0][0])) + ((12'(pm[1][2]) - 12'(pm[1][0])) <<< 1)
       + (12'(pm[2][2]) - 12'(pm[2][0]));
    gy = (12'(pm[2][0]) + (12'(pm[2][1]) << 1) + 12'(pm[2][2]))
       - (12'(pm[0][0]) + (12'(pm[0][1]) << 1) + 12'(pm[0][2]));
  end

  // gradients, sum of squares, bitwise root
  logic signed [10:0] gx_q, gy_q;
  logic signed [21:0] gx2, gy2;
  logic [20:0]        rem_q, res_q, bit_q;
  logic [21:0]        trial;
  logic [27:0]        scaled;
  logic [19:0]        sh;

  assign gx2    = gx_q * gx_q;
  assign gy2    = gy_q * gy_q;
  assign trial  = {1'b0, res_q} + {1'b0, bit_q};
  assign scaled = 28'(sens_q) * 28'(res_q[sem_pkg::SQRT_BITS-1:0]) + 28'd128;
  assign sh     = scaled[27:8];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sob) begin
      gx_q <= gx[10:0];
      gy_q <= gy[10:0];
    end
    if (cmd_i.sqr) begin
      rem_q <= 21'(gx2) + 21'(gy2);
      res_q <= '0;
      bit_q <= 21'(1) << (2 * (sem_pkg::SQRT_BITS - 1));
    end else if (cmd_i.sqrt_step) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_q <= rem_q - trial[20:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // result register
  logic        out_valid_q;
  logic [7:0]  out_edge_q;
  logic [11:0] out_row_q;
  logic [9:0]  out_col_q;
  logic        out_last_q, out_done_q;
  logic [31:0] row_w, col_w;

  assign row_w = 32'(out_r);
  assign col_w = 32'(out_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.scale) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      out_edge_q <= (sh > 20'd255) ? 8'd255 : sh[7:0];
      out_row_q  <= row_w[11:0];
      out_col_q  <= col_w[9:0];
      out_last_q <= cmd_i.last;
      out_done_q <= at_bot && at_rgt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {2'b00, out_col_q, out_row_q, out_edge_q};
  assign out_last_o  = out_last_q;
  assign out_done_o  = out_done_q;

  assign status_o.rmask     = {HX'(crow_q) == h_m1, crow_q != '0};
  assign status_o.cmask     = {WX'(ccol_q) == w_m1, ccol_q != '0};
  assign status_o.sqrt_last = bit_q[0];
  assign status_o.out_fire  = out_valid_q && out_ready_i;

`ifndef ASSERT_OFF
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !out_valid_q) else $error("pixel taken while result pending");
  a_scale_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scale |=> out_valid_q) else $error("scaled result not presented");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(cmd_i.sob || cmd_i.scale)) else $error("result register busy");
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> out_last_q) else $error("frame end not last");
`endif

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the sobel edge magnitude core
`timescale 1ns / 1ps
module tb_top;

  localparam int MAXW       = 1024;
  localparam int MAXH       = 4096;
  localparam int IDLE_LIMIT = 5000;  // cycles with no handshake before giving up
  localparam int DRAIN      = 30;    // covers a pixel that makes no result

  typedef struct {
    logic [7:0]  edge_val;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
    logic        done;
  } result_t;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;
  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [15:0] wval;
    logic [23:0] rgb;       // blue, green, red
    logic        chk;
    logic [7:0]  exp_edge;  // every result of the pixel carries this value
  } dir_row_t;

  // short frames that show corner behavior: 1x1, zero sizes, saturation, zero gain
  localparam int NDIR = 23;
  localparam dir_row_t DIR_TAB[NDIR] = '{
    '{ROW_CFG, sem_pkg::CFG_FRAME_WIDTH,  16'd1,     24'h0, 1'b0, 8'd0},
    '{ROW_CFG, sem_pkg::CFG_FRAME_HEIGHT, 16'd1,     24'h0, 1'b0, 8'd0},
    '{ROW_CFG, sem_pkg::CFG_SENSITIVITY,  16'd256,   24'h0, 1'b0, 8'd0},
    '{ROW_PIX, sem_pkg::CFG_FRAME_WIDTH,  16'd0, 24'h0000FF, 1'b1, 8'd0},
    '{ROW_PIX, sem_pkg::CFG_FRAME_WIDTH,  16'd0, 24'h00FF00, 1'b1, 8'd0},
    '{ROW_PIX, sem_pkg::CFG_FRAME_WIDTH,  16'd0, 24'hFF0000, 1'b1, 8'd0},
    '{ROW_CFG, sem_pkg::CFG_SENSITIVITY,  16'd0,     24'h0, 1'b0, 8'd0},
    '{ROW_PIX, sem_pkg::CFG_FRAME_WIDTH,  16'd0, 24'hFFFFFF, 1'b1, 8'd0},
    '{ROW_CFG, sem_pkg::CFG_FRAME_WIDTH,  16'd2,     24'h0, 1'b0, 8'd0},
    '{ROW_CFG, sem_pkg::CFG_FRAME_HEIGHT, 16'd2,     24'h0, 1'b0, 8'd0},
    '{ROW_CFG, sem_pkg::CFG_SENSITIVITY,  16'd256,   24'h0, 1'b0, 8'd0},
    '{ROW_PIX, sem_pkg::CFG_FRAME_WIDTH,  16'd0, 24'hFFFFFF, 1'b0, 8'd0},
    '{ROW_PIX, sem_pkg::CFG_FRAME_WIDTH,  16'd0, 24'h000000, 1'b0, 8'd0},
    '{ROW_PIX, sem_pkg::CFG_FRAME_WIDTH,  16'd0, 24'hFFFFFF, 1'b0, 8'd0},
    '{ROW_PIX, sem_pkg::CFG_FRAME_WIDTH,  16'd0, 24'h000000, 1'b1, 8'd255},
    '{ROW_CFG, sem_pkg::CFG_SENSITIVITY,  16'd65535, 24'h0, 1'b0, 8'd0},
    '{ROW_PIX, sem_pkg::CFG_FRAME_WIDTH,  16'd0, 24'h000000, 1'b0, 8'd0},
    '{ROW_PIX, sem_pkg::CFG_FRAME_WIDTH,  16'd0, 24'hFFFFFF, 1'b0, 8'd0},
    '{ROW_PIX, sem_pkg::CFG_FRAME_WIDTH,  16'd0, 24'h000000, 1'b0, 8'd0},
    '{ROW_PIX, sem_pkg::CFG_FRAME_WIDTH,  16'd0, 24'hFFFFFF, 1'b1, 8'd255},
    '{ROW_CFG, sem_pkg::CFG_FRAME_WIDTH,  16'd0,     24'h0, 1'b0, 8'd0},
    '{ROW_CFG, sem_pkg::CFG_FRAME_HEIGHT, 16'd0,     24'h0, 1'b0, 8'd0},
    '{ROW_PIX, sem_pkg::CFG_FRAME_WIDTH,  16'd0, 24'h204080, 1'b1, 8'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [23:0] s_data = '0;
  logic        m_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  logic        s_axis_tready, m_axis_tvalid, m_axis_tlast, m_axis_tuser, cfg_ready_o;
  logic [31:0] m_axis_tdata;

  sobel_edge_magnitude_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata)
  );

  always #6 clk_i = ~clk_i;

  // mirror of the core's settings and pixel history
  int unsigned frame_w = 640, frame_h = 480, gain_q8 = 256;
  logic [7:0]  line_buf [0:2*MAXW-1];
  logic [7:0]  win [0:2][0:2];
  int          cur_row = 0, cur_col = 0;
  result_t     edge_q [$];
  int          err_cnt = 0;
  int          burst_left = 0;
  bit          hold_req = 1'b0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    err_cnt++;
  endtask

  function automatic int unsigned root_floor(input int unsigned v);
    int unsigned res;
    res = 0;
    for (int b = 15; b >= 0; b--)
      if ((res | (1 << b)) * (res | (1 << b)) <= v) res |= (1 << b);
    return res;
  endfunction

  // magnitude at (R, C) from the window whose newest gray value sits at (r, c)
  function automatic logic [7:0] edge_of(input int R, C, r, c, W, H);
    int gx, gy, rr, cc, wi, wj, p, kx, ky;
    int unsigned mag, v;
    gx = 0;
    gy = 0;
    for (int kr = 0; kr < 3; kr++) begin
      for (int kc = 0; kc < 3; kc++) begin
        rr = R + kr - 1;
        if (rr < 0) rr = 0;
        if (rr > H - 1) rr = H - 1;
        cc = C + kc - 1;
        if (cc < 0) cc = 0;
        if (cc > W - 1) cc = W - 1;
        wi = rr + 2 - r;
        wj = cc + 2 - c;
        p = (wi >= 0 && wi < 3 && wj >= 0 && wj < 3) ? int'(win[wi][wj]) : 0;
        kx = (kc - 1) * ((kr == 1) ? 2 : 1);
        ky = (kr - 1) * ((kc == 1) ? 2 : 1);
        gx += kx * p;
        gy += ky * p;
      end
    end
    mag = root_floor(gx * gx + gy * gy);
    v = (gain_q8 * mag + 128) >> 8;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // takes one pixel word, queues the results it causes, returns their count
  function automatic int predict_pixel(input logic [23:0] d);
    int W, H, r, c, n, nr, nc;
    int rows [2];
    int cols [2];
    logic [7:0] gray;
    result_t res;
    W = (frame_w < 1) ? 1 : (frame_w > MAXW) ? MAXW : frame_w;
    H = (frame_h < 1) ? 1 : (frame_h > MAXH) ? MAXH : frame_h;
    if (cur_col >= W) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= H) cur_row = 0;
    r = cur_row;
    c = cur_col;
    gray = 8'((299 * int'(d[7:0]) + 587 * int'(d[15:8]) + 114 * int'(d[23:16])) / 1000);
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = line_buf[MAXW + c];
    win[1][2] = line_buf[c];
    win[2][2] = gray;
    line_buf[MAXW + c] = line_buf[c];
    line_buf[c] = gray;
    nr = 0;
    nc = 0;
    if (r >= 1) begin
      rows[nr] = r - 1;
      nr++;
    end
    if (r == H - 1) begin
      rows[nr] = r;
      nr++;
    end
    if (c >= 1) begin
      cols[nc] = c - 1;
      nc++;
    end
    if (c == W - 1) begin
      cols[nc] = c;
      nc++;
    end
    n = 0;
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        res.edge_val = edge_of(rows[i], cols[j], r, c, W, H);
        res.row = 12'(rows[i]);
        res.col = 10'(cols[j]);
        res.last = 1'b0;
        res.done = (rows[i] == H - 1 && cols[j] == W - 1);
        edge_q.push_back(res);
        n++;
      end
    end
    if (n > 0) edge_q[edge_q.size() - 1].last = 1'b1;
    cur_col = c + 1;
    if (cur_col >= W) begin
      cur_col = 0;
      cur_row = r + 1;
      if (cur_row >= H) cur_row = 0;
    end
    return n;
  endfunction

  // offer one pixel word, with bursts and random gaps between them
  task automatic send_pixel(input logic [23:0] d, output int n);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i) s_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    n = predict_pixel(d);
  endtask

  // drop valid and let every pending result drain
  task automatic settle();
    @(negedge clk_i) s_valid <= 1'b0;
    burst_left = 0;
    while (edge_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sem_pkg::CFG_FRAME_WIDTH:  frame_w = 32'(val[10:0]);
      sem_pkg::CFG_FRAME_HEIGHT: frame_h = 32'(val[12:0]);
      sem_pkg::CFG_SENSITIVITY:  gain_q8 = 32'(val);
      default: ;
    endcase
    @(negedge clk_i) cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input int npix);
    int n;
    for (int i = 0; i < npix; i++) send_pixel({rand_chan(), rand_chan(), rand_chan()}, n);
  endtask

  // receiver: runs of always-ready, coin-flip and mostly-ready, plus long hold-offs
  initial begin
    int mode, len;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk_i) m_ready <= 1'b0;
        repeat (600) @(negedge clk_i);
      end else begin
        mode = $urandom_range(0, 2);
        len = $urandom_range(5, 60);
        repeat (len) begin
          @(negedge clk_i);
          case (mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // result checker: compare each taken word with the oldest expectation
  always @(posedge clk_i) begin
    result_t e;
    if (m_axis_tvalid && m_ready) begin
      if (edge_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", m_axis_tdata));
      end else begin
        e = edge_q.pop_front();
        if (m_axis_tdata[7:0] !== e.edge_val)
          report_mismatch($sformatf("edge r%0d c%0d got %0d want %0d",
                                    e.row, e.col, m_axis_tdata[7:0], e.edge_val));
        if (m_axis_tdata[19:8] !== e.row)
          report_mismatch($sformatf("row got %0d want %0d", m_axis_tdata[19:8], e.row));
        if (m_axis_tdata[29:20] !== e.col)
          report_mismatch($sformatf("col got %0d want %0d", m_axis_tdata[29:20], e.col));
        if (m_axis_tlast !== e.last)
          report_mismatch($sformatf("tlast r%0d c%0d got %b", e.row, e.col, m_axis_tlast));
        if (m_axis_tuser !== e.done)
          report_mismatch($sformatf("tuser r%0d c%0d got %b", e.row, e.col, m_axis_tuser));
      end
    end
  end

  // watchdog on cycles with no handshake at all
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) ||
        (cfg_valid && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int n, pix_cnt, frames, W, H;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int k = 0; k < NDIR; k++) begin
      if (DIR_TAB[k].kind == ROW_CFG) begin
        settle();
        write_reg(DIR_TAB[k].reg_idx, DIR_TAB[k].wval);
      end else begin
        send_pixel(DIR_TAB[k].rgb, n);
        if (DIR_TAB[k].chk)
          for (int j = edge_q.size() - n; j < edge_q.size(); j++)
            if (edge_q[j].edge_val !== DIR_TAB[k].exp_edge)
              report_mismatch($sformatf("table row %0d edge %0d want %0d",
                                        k, edge_q[j].edge_val, DIR_TAB[k].exp_edge));
      end
    end

    // random small frames, fresh settings each frame
    pix_cnt = 0;
    frames = 0;
    while (pix_cnt < 145) begin
      settle();
      W = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 5);
      H = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 5);
      write_reg(sem_pkg::CFG_FRAME_WIDTH, 16'(W));
      write_reg(sem_pkg::CFG_FRAME_HEIGHT, 16'(H));
      case ($urandom_range(0, 5))
        0:       write_reg(sem_pkg::CFG_SENSITIVITY, 16'd0);
        1:       write_reg(sem_pkg::CFG_SENSITIVITY, 16'hFFFF);
        2:       write_reg(sem_pkg::CFG_SENSITIVITY, 16'd256);
        3:       write_reg(sem_pkg::CFG_SENSITIVITY, 16'($urandom_range(0, 65535)));
        default: write_reg(sem_pkg::CFG_SENSITIVITY, 16'($urandom_range(64, 1024)));
      endcase
      if (W < 1) W = 1;
      if (H < 1) H = 1;
      // one frame runs into a long output hold-off so the input backs up
      if (frames == 2) hold_req = 1'b1;
      send_frame(W * H);
      pix_cnt += W * H;
      frames++;
    end

    settle();
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/sem_pkg.sv
sv/sem_ctrl.sv
sv/sem_datapath.sv
sv/sobel_edge_magnitude_core.sv
dv/tb_top.sv
